/* rtl/slt_pkg.sv */
// Shared types, character codes and result codes for the shell line tokenizer.
// Used by slt_step, slt_outbuf and shell_line_tokenizer; depends on nothing.
`default_nettype none

package slt_pkg;

	localparam logic [1:0] KIND_BYTE = 2'd0;
	localparam logic [1:0] KIND_END  = 2'd1;
	localparam logic [1:0] KIND_LINE = 2'd2;
	localparam logic [1:0] KIND_ERR  = 2'd3;

	localparam logic [2:0] TYPE_WORD   = 3'd0;
	localparam logic [2:0] TYPE_PIPE   = 3'd1;
	localparam logic [2:0] TYPE_OUT    = 3'd2;
	localparam logic [2:0] TYPE_APPEND = 3'd3;
	localparam logic [2:0] TYPE_IN     = 3'd4;
	localparam logic [2:0] TYPE_BG     = 3'd5;

	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_PIPE  = 8'h7C;
	localparam logic [7:0] CH_AMP   = 8'h26;
	localparam logic [7:0] CH_SQ    = 8'h27;
	localparam logic [7:0] CH_DQ    = 8'h22;
	localparam logic [7:0] CH_BS    = 8'h5C;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;

	localparam int MAX_RESULTS = 4;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] out_byte;
		logic [2:0] token_type;
		logic [5:0] token_number;
		logic [6:0] token_total;
		logic       overflowed;
		logic       final_of_run;
	} res_t;

	function automatic res_t mk_res(logic [1:0] kind, logic [7:0] b, logic [2:0] typ,
			logic [5:0] num, logic [6:0] total, logic ovf);
		res_t r;
		r.kind         = kind;
		r.out_byte     = b;
		r.token_type   = typ;
		r.token_number = num;
		r.token_total  = total;
		r.overflowed   = ovf;
		r.final_of_run = 1'b0;
		return r;
	endfunction

	function automatic logic is_space(logic [7:0] c);
		return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
	endfunction

	function automatic logic is_op(logic [7:0] c);
		return (c == CH_GT) || (c == CH_LT) || (c == CH_PIPE) || (c == CH_AMP);
	endfunction

endpackage

`default_nettype wire

/* rtl/slt_step.sv */
// Tokenizer state register and the single-pass logic that turns one word into
// up to four results. Depends on slt_pkg.
`default_nettype none

module slt_step import slt_pkg::*; #(
	parameter int TOKENS_PER_LINE = 64,
	parameter int TOKEN_CAPACITY  = 256
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   advance,
	input  wire logic [7:0]             char_byte,
	input  wire logic                   line_end,
	output res_t [MAX_RESULTS-1:0]      results,
	output logic [2:0]                  result_count
);

	localparam int LW = $clog2(TOKEN_CAPACITY + 1);
	localparam int CW = $clog2(TOKENS_PER_LINE + 1);
	localparam logic [LW-1:0] CAP_L = LW'(TOKEN_CAPACITY);
	localparam logic [CW-1:0] TPL_C = CW'(TOKENS_PER_LINE);

	typedef struct packed {
		logic          sq;
		logic          dq;
		logic          esc;
		logic          act;
		logic          gp;
		logic [LW-1:0] len;
		logic [15:0]   fb;
		logic [CW-1:0] cnt;
		logic          sat;
		logic          ovf;
	} tok_state_t;

	tok_state_t state_q;
	tok_state_t st;
	res_t [MAX_RESULTS-1:0] r;
	logic [2:0] n;
	logic [2:0] nm1;
	logic done;
	logic quoted;

	function automatic logic [5:0] num6(logic [CW-1:0] cnt);
		logic [CW+6:0] w;
		w = {7'd0, cnt};
		return w[5:0];
	endfunction

	function automatic logic [6:0] tot7(logic [CW-1:0] cnt);
		logic [CW+6:0] w;
		w = {7'd0, cnt};
		return w[6:0];
	endfunction

	function automatic logic [2:0] classify(tok_state_t s);
		logic [2:0] t;
		t = TYPE_WORD;
		if (!s.ovf) begin
			if (s.len == LW'(1)) begin
				case (s.fb[7:0])
					CH_PIPE: t = TYPE_PIPE;
					CH_GT:   t = TYPE_OUT;
					CH_LT:   t = TYPE_IN;
					CH_AMP:  t = TYPE_BG;
					default: t = TYPE_WORD;
				endcase
			end else if (s.len == LW'(2) && s.fb[7:0] == CH_GT && s.fb[15:8] == CH_GT) begin
				t = TYPE_APPEND;
			end
		end
		return t;
	endfunction

	function automatic res_t end_res(tok_state_t s);
		return mk_res(KIND_END, 8'h00, classify(s), num6(s.cnt), 7'd0, s.ovf);
	endfunction

	function automatic res_t byte_res(tok_state_t s, logic [7:0] c);
		return mk_res(KIND_BYTE, c, TYPE_WORD, num6(s.cnt), 7'd0, 1'b0);
	endfunction

	function automatic tok_state_t end_st(tok_state_t s);
		tok_state_t o;
		o = s;
		o.cnt = s.cnt + CW'(1);
		o.act = 1'b0;
		o.gp  = 1'b0;
		o.len = '0;
		o.fb  = '0;
		o.ovf = 1'b0;
		if (o.cnt >= TPL_C) begin
			o.sat = 1'b1;
		end
		return o;
	endfunction

	function automatic tok_state_t acc_st(tok_state_t s, logic [7:0] c);
		tok_state_t o;
		o = s;
		o.act = 1'b1;
		if (s.len < CAP_L) begin
			if (s.len == '0) begin
				o.fb = {8'h00, c};
			end else if (s.len == LW'(1)) begin
				o.fb[15:8] = c;
			end
			o.len = s.len + LW'(1);
		end else begin
			o.ovf = 1'b1;
		end
		return o;
	endfunction

	always_comb begin
		st     = state_q;
		r      = '0;
		n      = 3'd0;
		done   = 1'b0;
		quoted = 1'b0;
		if (char_byte != 8'h00 && !st.sat) begin
			if (st.gp) begin
				if (char_byte == CH_GT) begin
					if (st.len < CAP_L) begin
						r[n[1:0]] = byte_res(st, char_byte);
						n = n + 3'd1;
					end
					st = acc_st(st, char_byte);
					r[n[1:0]] = end_res(st);
					n = n + 3'd1;
					st = end_st(st);
					done = 1'b1;
				end else begin
					r[n[1:0]] = end_res(st);
					n = n + 3'd1;
					st = end_st(st);
					done = st.sat;
				end
			end
			if (!done) begin
				quoted = st.sq | st.dq;
				if (st.esc) begin
					st.esc = 1'b0;
					if (st.len < CAP_L) begin
						r[n[1:0]] = byte_res(st, char_byte);
						n = n + 3'd1;
					end
					st = acc_st(st, char_byte);
				end else if (char_byte == CH_SQ && !st.dq) begin
					st.sq  = ~st.sq;
					st.act = 1'b1;
				end else if (char_byte == CH_DQ && !st.sq) begin
					st.dq  = ~st.dq;
					st.act = 1'b1;
				end else if (char_byte == CH_BS && st.dq) begin
					st.esc = 1'b1;
					st.act = 1'b1;
				end else if (!quoted && is_space(char_byte)) begin
					if (st.act) begin
						r[n[1:0]] = end_res(st);
						n = n + 3'd1;
						st = end_st(st);
					end
				end else if (!quoted && is_op(char_byte)) begin
					if (st.len != '0) begin
						r[n[1:0]] = end_res(st);
						n = n + 3'd1;
						st = end_st(st);
					end
					if (!st.sat) begin
						if (st.len < CAP_L) begin
							r[n[1:0]] = byte_res(st, char_byte);
							n = n + 3'd1;
						end
						st = acc_st(st, char_byte);
						if (char_byte == CH_GT) begin
							st.gp = 1'b1;
						end else begin
							r[n[1:0]] = end_res(st);
							n = n + 3'd1;
							st = end_st(st);
						end
					end
				end else begin
					if (st.len < CAP_L) begin
						r[n[1:0]] = byte_res(st, char_byte);
						n = n + 3'd1;
					end
					st = acc_st(st, char_byte);
				end
			end
		end
		if (line_end) begin
			if (!st.sat && (st.sq || st.dq)) begin
				r[n[1:0]] = mk_res(KIND_ERR, 8'h00, TYPE_WORD, 6'd0, tot7(st.cnt), 1'b0);
				n = n + 3'd1;
			end else begin
				if (!st.sat && st.act) begin
					r[n[1:0]] = end_res(st);
					n = n + 3'd1;
					st = end_st(st);
				end
				r[n[1:0]] = mk_res(KIND_LINE, 8'h00, TYPE_WORD, 6'd0, tot7(st.cnt), 1'b0);
				n = n + 3'd1;
			end
			st = '0;
		end
		nm1 = n - 3'd1;
		if (n != 3'd0) begin
			r[nm1[1:0]].final_of_run = 1'b1;
		end
	end

	assign results      = r;
	assign result_count = n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= st;
		end
	end

endmodule

`default_nettype wire

/* rtl/slt_outbuf.sv */
// Result register with room for the up to four results of one word; hands
// them out one per cycle while out_ready is high. Depends on slt_pkg.
`default_nettype none

module slt_outbuf import slt_pkg::*; (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   load,
	input  wire logic [2:0]             load_count,
	input  wire res_t [MAX_RESULTS-1:0] load_results,
	output logic                        room,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output res_t                        head
);

	res_t       res_q [MAX_RESULTS];
	logic [2:0] cnt_q;
	logic       pop;

	assign out_valid = (cnt_q != 3'd0);
	assign pop       = out_valid && out_ready;
	assign room      = (cnt_q == 3'd0) || (cnt_q == 3'd1 && out_ready);
	assign head      = res_q[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 3'd0;
		end else if (load) begin
			cnt_q <= load_count;
		end else if (pop) begin
			cnt_q <= cnt_q - 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			for (int i = 0; i < MAX_RESULTS; i++) begin
				res_q[i] <= load_results[i];
			end
		end else if (pop) begin
			for (int i = 0; i < MAX_RESULTS - 1; i++) begin
				res_q[i] <= res_q[i+1];
			end
		end
	end

	// A new batch may only land when the previous one is drained or its last result is taken in that cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		load && load_count != 3'd0 |=> cnt_q == $past(load_count))
		else $error("result batch not registered");
	assert property (@(posedge clk) disable iff (!arst_n)
		load |-> (cnt_q == 3'd0 || (cnt_q == 3'd1 && out_ready)))
		else $error("result batch overwrote pending results");
	assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == 3'd1 |-> res_q[0].final_of_run)
		else $error("last pending result lacks final_of_run");
	assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q > 3'd1 |-> !res_q[0].final_of_run)
		else $error("final_of_run set before the last result");
	assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 3'd4)
		else $error("result count out of range");

endmodule

`default_nettype wire

/* rtl/shell_line_tokenizer.sv */
// Top level of the shell line tokenizer: input register, tokenizer step logic
// and result register. Depends on slt_pkg, slt_step and slt_outbuf.
//
// Usage: command-line bytes enter on the in channel (in_valid, in_ready,
// char_byte, line_end), one word per byte. Results leave on the out channel
// (out_valid, out_ready, kind, out_byte, token_type, token_number,
// token_total, overflowed, final_of_run), one per cycle while out_ready is
// high; final_of_run marks the last result caused by an input word. A word
// that yields no result (zero byte, separating whitespace, quote marks)
// produces nothing. A word leaves the input register once the result
// register has room, so one word per cycle is sustained while out_ready
// is high and each word yields at most one result; a word with several
// results hands them out one at a time, and the input register holds the
// next word until the last of them is taken. When the receiver stalls,
// results stay in the result register and the input side fills and then
// drops in_ready. Reset clears the tokenizer state, the input register and
// all pending results; no clearing pass is needed and a word is accepted
// in the first cycle after reset.
`default_nettype none

module shell_line_tokenizer import slt_pkg::*; #(
	parameter int TOKENS_PER_LINE = 64,
	parameter int TOKEN_CAPACITY  = 256
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] char_byte,
	input  wire logic       line_end,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [1:0]      kind,
	output logic [7:0]      out_byte,
	output logic [2:0]      token_type,
	output logic [5:0]      token_number,
	output logic [6:0]      token_total,
	output logic            overflowed,
	output logic            final_of_run
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       line_end_s1;
	logic       room;
	logic       advance;
	logic [2:0] result_count;
	res_t [MAX_RESULTS-1:0] results;
	res_t       head;

	assign advance  = valid_s1 && room;
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1     <= char_byte;
			line_end_s1 <= line_end;
		end
	end

	slt_step #(
		.TOKENS_PER_LINE(TOKENS_PER_LINE),
		.TOKEN_CAPACITY (TOKEN_CAPACITY)
	) u_step (
		.clk         (clk),
		.arst_n      (arst_n),
		.advance     (advance),
		.char_byte   (byte_s1),
		.line_end    (line_end_s1),
		.results     (results),
		.result_count(result_count)
	);

	slt_outbuf u_outbuf (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (advance),
		.load_count  (result_count),
		.load_results(results),
		.room        (room),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.head        (head)
	);

	assign kind         = head.kind;
	assign out_byte     = head.out_byte;
	assign token_type   = head.token_type;
	assign token_number = head.token_number;
	assign token_total  = head.token_total;
	assign overflowed   = head.overflowed;
	assign final_of_run = head.final_of_run;

endmodule

`default_nettype wire

/* tb/tb.sv */
// Self-checking testbench for shell_line_tokenizer: directed, limit and random command lines,
// predicted byte by byte and compared result by result, with random idling on both channels.
// Depends on slt_pkg (result codes, character codes, res_t) and the shell_line_tokenizer RTL.
module tb;
	import slt_pkg::*;

	localparam int TOKENS_PER_LINE = 64;
	localparam int TOKEN_CAPACITY  = 256;
	localparam int STALL_LIMIT     = 2000;
	localparam int RANDOM_WORDS    = 30;
	localparam logic [7:0] NO_CHAR = 8'h00;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic [7:0] char_byte;
	logic       line_end;
	logic       out_valid;
	logic       out_ready;
	logic [1:0] kind;
	logic [7:0] out_byte;
	logic [2:0] token_type;
	logic [5:0] token_number;
	logic [6:0] token_total;
	logic       overflowed;
	logic       final_of_run;

	res_t       token_events[$];
	res_t       step_events[$];
	logic [7:0] line_q[$];

	logic        sq_open, dq_open, esc_pend, in_token, gt_pend, line_full, len_over;
	int unsigned tok_len, tok_count;
	logic [7:0]  lead_byte, second_byte;

	int errors, words_sent, results_seen, lines_sent, idle_cycles;
	int tx_max_gap, rx_max_stall, rx_hold_cycles;

	shell_line_tokenizer #(
		.TOKENS_PER_LINE(TOKENS_PER_LINE),
		.TOKEN_CAPACITY (TOKEN_CAPACITY)
	) i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.char_byte   (char_byte),
		.line_end    (line_end),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.kind        (kind),
		.out_byte    (out_byte),
		.token_type  (token_type),
		.token_number(token_number),
		.token_total (token_total),
		.overflowed  (overflowed),
		.final_of_run(final_of_run)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic logic blank_char(logic [7:0] c);
		return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
	endfunction

	function automatic logic operator_char(logic [7:0] c);
		return (c == CH_GT) || (c == CH_LT) || (c == CH_PIPE) || (c == CH_AMP);
	endfunction

	function automatic void post_event(logic [1:0] k, logic [7:0] b, logic [2:0] t,
			int unsigned num, int unsigned total, logic ovf);
		res_t r;
		if (step_events.size() >= MAX_RESULTS)
			return;
		r.kind         = k;
		r.out_byte     = b;
		r.token_type   = t;
		r.token_number = num[5:0];
		r.token_total  = total[6:0];
		r.overflowed   = ovf;
		r.final_of_run = 1'b0;
		step_events.push_back(r);
	endfunction

	function automatic void clear_line();
		sq_open     = 1'b0;
		dq_open     = 1'b0;
		esc_pend    = 1'b0;
		in_token    = 1'b0;
		gt_pend     = 1'b0;
		line_full   = 1'b0;
		len_over    = 1'b0;
		tok_len     = 0;
		tok_count   = 0;
		lead_byte   = NO_CHAR;
		second_byte = NO_CHAR;
	endfunction

	// A token that lost bytes is always a word; otherwise the kept bytes decide.
	function automatic logic [2:0] token_class();
		if (len_over)
			return TYPE_WORD;
		if (tok_len == 1) begin
			case (lead_byte)
				CH_PIPE: return TYPE_PIPE;
				CH_GT:   return TYPE_OUT;
				CH_LT:   return TYPE_IN;
				CH_AMP:  return TYPE_BG;
				default: ;
			endcase
		end else if (tok_len == 2 && lead_byte == CH_GT && second_byte == CH_GT) begin
			return TYPE_APPEND;
		end
		return TYPE_WORD;
	endfunction

	function automatic void close_token();
		post_event(KIND_END, NO_CHAR, token_class(), tok_count, 0, len_over);
		tok_count++;
		in_token    = 1'b0;
		gt_pend     = 1'b0;
		tok_len     = 0;
		lead_byte   = NO_CHAR;
		second_byte = NO_CHAR;
		len_over    = 1'b0;
		if (tok_count >= TOKENS_PER_LINE)
			line_full = 1'b1;
	endfunction

	function automatic void keep_byte(logic [7:0] c);
		in_token = 1'b1;
		if (tok_len < TOKEN_CAPACITY) begin
			post_event(KIND_BYTE, c, TYPE_WORD, tok_count, 0, 1'b0);
			if (tok_len == 0) begin
				lead_byte   = c;
				second_byte = NO_CHAR;
			end else if (tok_len == 1) begin
				second_byte = c;
			end
			tok_len++;
		end else begin
			len_over = 1'b1;
		end
	endfunction

	function automatic void scan_byte(logic [7:0] c);
		logic quoted;
		if (gt_pend) begin
			if (c == CH_GT) begin
				keep_byte(c);
				close_token();
				return;
			end
			close_token();
			if (line_full)
				return;
		end
		quoted = sq_open || dq_open;
		if (esc_pend) begin
			esc_pend = 1'b0;
			keep_byte(c);
		end else if (c == CH_SQ && !dq_open) begin
			sq_open  = !sq_open;
			in_token = 1'b1;
		end else if (c == CH_DQ && !sq_open) begin
			dq_open  = !dq_open;
			in_token = 1'b1;
		end else if (c == CH_BS && dq_open) begin
			esc_pend = 1'b1;
			in_token = 1'b1;
		end else if (!quoted && blank_char(c)) begin
			if (in_token)
				close_token();
		end else if (!quoted && operator_char(c)) begin
			if (tok_len != 0) begin
				close_token();
				if (line_full)
					return;
			end
			keep_byte(c);
			if (c == CH_GT)
				gt_pend = 1'b1;
			else
				close_token();
		end else begin
			keep_byte(c);
		end
	endfunction

	function automatic void tokenize_word(logic [7:0] c, logic last);
		res_t tail;
		step_events.delete();
		if (c != NO_CHAR && !line_full)
			scan_byte(c);
		if (last) begin
			if (!line_full && (sq_open || dq_open)) begin
				post_event(KIND_ERR, NO_CHAR, TYPE_WORD, 0, tok_count, 1'b0);
			end else begin
				if (!line_full && in_token)
					close_token();
				post_event(KIND_LINE, NO_CHAR, TYPE_WORD, 0, tok_count, 1'b0);
			end
			clear_line();
		end
		if (step_events.size() > 0) begin
			tail = step_events.pop_back();
			tail.final_of_run = 1'b1;
			step_events.push_back(tail);
		end
		foreach (step_events[i])
			token_events.push_back(step_events[i]);
	endfunction

	function automatic void check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			errors++;
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
		end
	endfunction

	always @(posedge clk) begin
		res_t want;
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (token_events.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none, got kind %0d byte %0d",
					$time, kind, out_byte);
			end else begin
				want = token_events.pop_front();
				check_field("kind", want.kind, kind);
				check_field("out_byte", want.out_byte, out_byte);
				check_field("token_type", want.token_type, token_type);
				check_field("token_number", want.token_number, token_number);
				check_field("token_total", want.token_total, token_total);
				check_field("overflowed", want.overflowed, overflowed);
				check_field("final_of_run", want.final_of_run, final_of_run);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				idle_cycles = 0;
			end else if (idle_cycles >= STALL_LIMIT) begin
				$display("%0t: no handshake for %0d cycles, %0d results outstanding",
					$time, idle_cycles, token_events.size());
				$display("tb: failure");
				$finish;
			end else begin
				idle_cycles = idle_cycles + 1;
			end
		end
	end

	initial begin
		int n;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (rx_hold_cycles > 0)
				n = rx_hold_cycles;
			else
				n = $urandom_range(0, rx_max_stall);
			rx_hold_cycles = 0;
			if (n > 0) begin
				out_ready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	task automatic send_word(logic [7:0] c, logic last);
		int gap;
		gap = $urandom_range(0, tx_max_gap);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		char_byte <= c;
		line_end  <= last;
		do @(posedge clk); while (!in_ready);
		tokenize_word(c, last);
		words_sent++;
	endtask

	task automatic send_line();
		foreach (line_q[i])
			send_word(line_q[i], i == line_q.size() - 1);
		line_q.delete();
		lines_sent++;
	endtask

	task automatic pause_for_results();
		in_valid <= 1'b0;
		while (token_events.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic void push_text(string s);
		for (int i = 0; i < s.len(); i++)
			line_q.push_back(s[i]);
	endfunction

	function automatic logic [7:0] plain_byte();
		logic [7:0] b;
		do
			b = 8'($urandom_range(1, 255));
		while (blank_char(b) || operator_char(b) || b == CH_SQ || b == CH_DQ);
		return b;
	endfunction

	function automatic logic [7:0] quoted_byte(logic [7:0] q);
		logic [7:0] b;
		do
			b = 8'($urandom_range(1, 255));
		while (b == q || (q == CH_DQ && b == CH_BS));
		return b;
	endfunction

	function automatic logic [7:0] blank_byte();
		logic [7:0] b;
		if ($urandom_range(0, 1))
			b = CH_SPACE;
		else
			b = 8'($urandom_range(CH_TAB, CH_CR));
		return b;
	endfunction

	function automatic logic [7:0] operator_byte();
		case ($urandom_range(0, 3))
			0: return CH_PIPE;
			1: return CH_AMP;
			2: return CH_LT;
			default: return CH_GT;
		endcase
	endfunction

	function automatic void build_random_line();
		int tokens, len;
		logic [7:0] q;
		tokens = $urandom_range(1, 8);
		for (int t = 0; t < tokens; t++) begin
			if (t > 0 && $urandom_range(0, 4) != 0) begin
				repeat ($urandom_range(1, 2)) line_q.push_back(blank_byte());
			end
			len = $urandom_range(0, 5);
			case ($urandom_range(0, 9))
				0, 1, 2: begin
					repeat (len + 1) line_q.push_back(plain_byte());
				end
				3: begin
					if ($urandom_range(0, 4) == 0)
						push_text(">>");
					else
						line_q.push_back(operator_byte());
				end
				4: begin
					line_q.push_back(CH_SQ);
					repeat (len) line_q.push_back(quoted_byte(CH_SQ));
					line_q.push_back(CH_SQ);
				end
				5: begin
					line_q.push_back(CH_DQ);
					repeat (len) begin
						if ($urandom_range(0, 3) == 0) begin
							line_q.push_back(CH_BS);
							line_q.push_back(8'($urandom_range(1, 255)));
						end else begin
							line_q.push_back(quoted_byte(CH_DQ));
						end
					end
					line_q.push_back(CH_DQ);
				end
				6: begin
					q = $urandom_range(0, 1) ? CH_SQ : CH_DQ;
					line_q.push_back(q);
					line_q.push_back(q);
					if ($urandom_range(0, 1))
						line_q.push_back(operator_byte());
				end
				7: begin
					line_q.push_back(plain_byte());
					line_q.push_back(CH_DQ);
					repeat (len) line_q.push_back(quoted_byte(CH_DQ));
					line_q.push_back(CH_DQ);
					line_q.push_back(plain_byte());
				end
				8: begin
					repeat (len + 1) line_q.push_back(8'($urandom_range(0, 255)));
				end
				default: begin
					line_q.push_back(plain_byte());
					line_q.push_back(NO_CHAR);
					line_q.push_back(plain_byte());
				end
			endcase
		end
		case ($urandom_range(0, 11))
			0: begin
				line_q.push_back(CH_SQ);
				line_q.push_back(plain_byte());
			end
			1: begin
				line_q.push_back(CH_DQ);
				line_q.push_back(plain_byte());
				if ($urandom_range(0, 1))
					line_q.push_back(CH_BS);
			end
			2, 3: line_q.push_back(NO_CHAR);
			4, 5: line_q.push_back(blank_byte());
			default: ;
		endcase
	endfunction

	task automatic test_directed();
		push_text("''|&<");
		send_line();
		push_text("\"|\">>>");
		send_line();
		line_q = '{NO_CHAR, 8'hFF, CH_SPACE, CH_DQ, CH_DQ, CH_TAB, 8'h80, NO_CHAR};
		send_line();
		push_text("\"a\\");
		send_line();
		line_q.push_back(CH_SQ);
		send_line();
	endtask

	// One token that runs one byte past capacity, partly inside double quotes.
	task automatic test_token_length();
		line_q.push_back(CH_DQ);
		repeat (TOKEN_CAPACITY - 1) line_q.push_back(plain_byte());
		line_q.push_back(CH_DQ);
		repeat (2) line_q.push_back(plain_byte());
		line_q.push_back(CH_GT);
		send_line();
	endtask

	task automatic test_token_limit();
		string tails[2];
		tails = '{">a", "x|y"};
		foreach (tails[i]) begin
			repeat (TOKENS_PER_LINE - 1) line_q.push_back(CH_PIPE);
			push_text(tails[i]);
			send_line();
		end
	endtask

	task automatic test_backpressure();
		tx_max_gap     = 0;
		rx_max_stall   = 0;
		rx_hold_cycles = 150;
		repeat (2) begin
			push_text("a>b>>c|d&e<f");
			send_line();
		end
		pause_for_results();
		tx_max_gap   = 18;
		rx_max_stall = 18;
	endtask

	task automatic test_random();
		int first;
		first = words_sent;
		while (words_sent - first < RANDOM_WORDS) begin
			case ($urandom_range(0, 3))
				0: begin
					tx_max_gap   = 0;
					rx_max_stall = 0;
				end
				1: begin
					tx_max_gap   = 18;
					rx_max_stall = 0;
				end
				2: begin
					tx_max_gap   = 0;
					rx_max_stall = 18;
				end
				default: begin
					tx_max_gap   = 18;
					rx_max_stall = 18;
				end
			endcase
			build_random_line();
			send_line();
			if ($urandom_range(0, 7) == 0)
				pause_for_results();
		end
	endtask

	initial begin
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		char_byte      = NO_CHAR;
		line_end       = 1'b0;
		errors         = 0;
		words_sent     = 0;
		results_seen   = 0;
		lines_sent     = 0;
		idle_cycles    = 0;
		tx_max_gap     = 18;
		rx_max_stall   = 18;
		rx_hold_cycles = 0;
		clear_line();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		test_directed();
		pause_for_results();
		test_token_length();
		pause_for_results();
		test_token_limit();
		pause_for_results();
		test_backpressure();
		test_random();

		pause_for_results();
		repeat (8) @(posedge clk);
		errors += token_events.size();
		$display("summary: %0d words in %0d lines, %0d results checked, %0d errors",
			words_sent, lines_sent, results_seen, errors);
		$display("summary: quotes, escapes, operators, token capacity, token limit and stalls");
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

/* filelist.f */
rtl/slt_pkg.sv
rtl/slt_step.sv
rtl/slt_outbuf.sv
rtl/shell_line_tokenizer.sv
tb/tb.sv
